// ===== rtl/lbo_pkg.sv =====
// Shared types and codes for the LED blink and oneshot controller.
package lbo_pkg;

    // Command codes carried in the action field
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_ON      = 3'd1,
        ACT_OFF     = 3'd2,
        ACT_BLINK   = 3'd3,
        ACT_ONESHOT = 3'd4
    } t_action;

    // Per-LED mode codes, as reported in the result
    typedef enum logic [2:0] {
        MODE_OFF        = 3'd0,
        MODE_ON         = 3'd1,
        MODE_BLINK_DARK = 3'd2,
        MODE_BLINK_LIT  = 3'd3,
        MODE_ONESHOT    = 3'd4
    } t_mode;

    localparam int unsigned TIME_W = 16;

    // Control bundle from the top level to each LED unit
    typedef struct packed {
        logic              step;     // a transaction is taken this cycle
        logic              tick;     // the transaction is a tick
        logic              hit;      // the command targets this LED
        t_action           action;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic [TIME_W-1:0] now;      // millisecond count after this step
    } t_led_cmd;

endpackage

// ===== rtl/lbo_if.sv =====
// Handshake interfaces for the command input and the result output.
interface lbo_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic        led_select;
    logic [15:0] on_time;
    logic [15:0] off_time;

    modport source (output valid, output action, output led_select,
                    output on_time, output off_time, input ready);
    modport sink   (input valid, input action, input led_select,
                    input on_time, input off_time, output ready);
endinterface

interface lbo_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] lit_bits;
    logic [2:0] green_state;
    logic [2:0] blue_state;

    modport source (output valid, output lit_bits, output green_state,
                    output blue_state, input ready);
    modport sink   (input valid, input lit_bits, input green_state,
                    input blue_state, output ready);
endinterface

// ===== rtl/lbo_led_unit.sv =====
// State and next-state logic of one LED: mode, drive level, deadline, durations.
module lbo_led_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lbo_pkg::t_led_cmd i_cmd,
    output logic              o_n_drive,
    output lbo_pkg::t_mode    o_n_mode
);

    lbo_pkg::t_mode                  r_mode, n_mode;
    logic                            r_drive, n_drive;
    logic [lbo_pkg::TIME_W-1:0]      r_deadline, n_deadline;
    logic [lbo_pkg::TIME_W-1:0]      r_lit, n_lit;
    logic [lbo_pkg::TIME_W-1:0]      r_dark, n_dark;
    logic [lbo_pkg::TIME_W-1:0]      w_diff;
    logic                            w_expired;

    // Wrap-safe deadline check: reached when the signed difference is not negative
    assign w_diff    = i_cmd.now - r_deadline;
    assign w_expired = ~w_diff[lbo_pkg::TIME_W-1];

    // Work out the state after this transaction
    always_comb begin
        n_mode     = r_mode;
        n_drive    = r_drive;
        n_deadline = r_deadline;
        n_lit      = r_lit;
        n_dark     = r_dark;
        if (i_cmd.step && i_cmd.tick) begin
            if (w_expired) begin
                case (r_mode)
                    lbo_pkg::MODE_BLINK_DARK: begin
                        n_mode     = lbo_pkg::MODE_BLINK_LIT;
                        n_drive    = 1'b1;
                        n_deadline = r_deadline + r_lit;
                    end
                    lbo_pkg::MODE_BLINK_LIT: begin
                        n_mode     = lbo_pkg::MODE_BLINK_DARK;
                        n_drive    = 1'b0;
                        n_deadline = r_deadline + r_dark;
                    end
                    lbo_pkg::MODE_ONESHOT: begin
                        n_mode  = lbo_pkg::MODE_OFF;
                        n_drive = 1'b0;
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.step && i_cmd.hit) begin
            case (i_cmd.action)
                lbo_pkg::ACT_ON: begin
                    n_mode  = lbo_pkg::MODE_ON;
                    n_drive = 1'b1;
                end
                lbo_pkg::ACT_OFF: begin
                    n_mode  = lbo_pkg::MODE_OFF;
                    n_drive = 1'b0;
                end
                lbo_pkg::ACT_BLINK: begin
                    if (i_cmd.on_time == '0) begin
                        n_mode  = lbo_pkg::MODE_OFF;
                        n_drive = 1'b0;
                    end else if (i_cmd.off_time == '0) begin
                        n_mode  = lbo_pkg::MODE_ON;
                        n_drive = 1'b1;
                    end else begin
                        n_mode     = lbo_pkg::MODE_BLINK_LIT;
                        n_drive    = 1'b1;
                        n_lit      = i_cmd.on_time;
                        n_dark     = i_cmd.off_time;
                        n_deadline = i_cmd.now + i_cmd.on_time;
                    end
                end
                lbo_pkg::ACT_ONESHOT: begin
                    if (i_cmd.on_time == '0) begin
                        n_mode  = lbo_pkg::MODE_OFF;
                        n_drive = 1'b0;
                    end else begin
                        n_mode     = lbo_pkg::MODE_ONESHOT;
                        n_drive    = 1'b1;
                        n_deadline = i_cmd.now + i_cmd.on_time;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold the LED state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= lbo_pkg::MODE_OFF;
            r_drive    <= 1'b0;
            r_deadline <= '0;
            r_lit      <= '0;
            r_dark     <= '0;
        end else begin
            r_mode     <= n_mode;
            r_drive    <= n_drive;
            r_deadline <= n_deadline;
            r_lit      <= n_lit;
            r_dark     <= n_dark;
        end
    end

    assign o_n_drive = n_drive;
    assign o_n_mode  = n_mode;

endmodule

// ===== rtl/led_blink_oneshot_controller.sv =====
// Top level: millisecond counter, LED units and the registered result stage.
// The result of a transaction is registered and appears in the cycle after it is taken.
// Throughput: one transaction per cycle; the input is ready whenever the
// result register is empty or being taken in the same cycle.
// Reset (synchronous, active low) clears the counter, all LEDs to off and dark,
// and empties the result register.
module led_blink_oneshot_controller #(
    parameter int NUM_LEDS = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbo_in_if.sink     i_cmd,
    lbo_out_if.source  o_res
);

    logic                        w_take;
    logic                        w_tick;
    lbo_pkg::t_action            w_action;
    logic [lbo_pkg::TIME_W-1:0]  r_now, n_now;
    logic                        w_drive [NUM_LEDS];
    lbo_pkg::t_mode              w_mode  [NUM_LEDS];
    logic                        r_out_valid;
    logic [1:0]                  r_lit_bits, n_lit_bits;
    logic [2:0]                  r_green, n_green;
    logic [2:0]                  r_blue, n_blue;

    // Accept while the result register is free or draining
    assign i_cmd.ready = ~r_out_valid | o_res.ready;
    assign w_take      = i_cmd.valid & i_cmd.ready;
    assign w_action    = lbo_pkg::t_action'(i_cmd.action);
    assign w_tick      = (w_action == lbo_pkg::ACT_TICK);

    // Advance the millisecond count on a tick
    assign n_now = (w_take && w_tick) ? r_now + 1'b1 : r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else begin
            r_now <= n_now;
        end
    end

    // One unit for each LED
    for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
        lbo_pkg::t_led_cmd w_cmd;

        always_comb begin
            w_cmd.step     = w_take;
            w_cmd.tick     = w_tick;
            w_cmd.hit      = (32'(i_cmd.led_select) == g);
            w_cmd.action   = w_action;
            w_cmd.on_time  = i_cmd.on_time;
            w_cmd.off_time = i_cmd.off_time;
            w_cmd.now      = n_now;
        end

        lbo_led_unit u_led (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .o_n_drive (w_drive[g]),
            .o_n_mode  (w_mode[g])
        );
    end

    // Gather the first two LEDs into the result; an absent blue LED reads zero
    if (NUM_LEDS > 1) begin : g_blue
        assign n_lit_bits = {w_drive[1], w_drive[0]};
        assign n_blue     = w_mode[1];
    end else begin : g_no_blue
        assign n_lit_bits = {1'b0, w_drive[0]};
        assign n_blue     = lbo_pkg::MODE_OFF;
    end
    assign n_green = w_mode[0];

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_lit_bits <= n_lit_bits;
            r_green    <= n_green;
            r_blue     <= n_blue;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.lit_bits    = r_lit_bits;
    assign o_res.green_state = r_green;
    assign o_res.blue_state  = r_blue;

endmodule
